/* rtl/srcp_pkg.sv */
// ----------------------------------------------------------------------------
// SMTP reply code parser package
// Shared types and character constants for the reply code parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srcp_pkg;

  // Field widths of the stream payload.
  localparam int unsigned CodeW = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ColW  = 3;

  // Characters the parser looks for.
  localparam logic [ByteW-1:0] ChrZero = 8'h30;
  localparam logic [ByteW-1:0] ChrNine = 8'h39;
  localparam logic [ByteW-1:0] ChrDash = 8'h2D;
  localparam logic [ByteW-1:0] ChrCr   = 8'h0D;
  localparam logic [ByteW-1:0] ChrLf   = 8'h0A;

  // Line columns of interest; the column counter saturates at ColSat.
  localparam logic [ColW-1:0] ColSep = 3'd3;
  localparam logic [ColW-1:0] ColSat = 3'd4;

  // Reset value of the expected code register.
  localparam logic [CodeW-1:0] ExpectedCodeReset = 10'd220;

  // Input item kinds.
  typedef enum logic {
    KindData   = 1'b0,
    KindClosed = 1'b1
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StMatch   = 2'd0,
    StDiffer  = 2'd1,
    StTooLong = 2'd2,
    StClosed  = 2'd3
  } status_e;

  // Outcome of one parsed byte.
  typedef struct packed {
    logic             emit;
    status_e          status;
    logic [CodeW-1:0] code;
  } srcp_result_t;

endpackage : srcp_pkg

`default_nettype wire

/* rtl/srcp_parse.sv */
// ----------------------------------------------------------------------------
// SMTP reply code parser: line parser
// Holds the per-reply parse state and works out the outcome of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_parse
  import srcp_pkg::*;
#(
  parameter int unsigned MAX_REPLY_BYTES = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             kind_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [CodeW-1:0] expected_code_i,
  output srcp_result_t          res_o
);

  localparam int unsigned CntW = $clog2(MAX_REPLY_BYTES + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_REPLY_BYTES - 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             ok_q, ok_d;
  logic [CodeW-1:0] acc_q, acc_d;
  logic             found_q, found_d;
  logic             cr_q, cr_d;

  logic             is_digit;
  logic [CodeW-1:0] digit;
  logic [CodeW-1:0] acc_x10;

  assign is_digit = (byte_i inside {[ChrZero:ChrNine]});
  assign digit    = CodeW'(byte_i - ChrZero);
  // The accumulator stays below 100 before its third digit, so times ten fits.
  assign acc_x10  = {acc_q[CodeW-4:0], 3'b000} + {acc_q[CodeW-2:0], 1'b0};

  // Next parse state and the outcome of the current byte.
  always_comb begin
    cnt_d   = cnt_q;
    col_d   = col_q;
    ok_d    = ok_q;
    acc_d   = acc_q;
    found_d = found_q;
    cr_d    = cr_q;
    res_o   = '{emit: 1'b0, status: StMatch, code: '0};

    if (kind_i == KindClosed) begin
      res_o = '{emit: 1'b1, status: StClosed, code: '0};
    end else if (cnt_q == CntLast) begin
      // The limit byte ends the reply even if it would have completed it.
      res_o = '{emit: 1'b1, status: StTooLong, code: '0};
    end else begin
      if (!found_q) begin
        if (col_q < ColSep) begin
          if (is_digit) begin
            acc_d = acc_x10 + digit;
          end else begin
            ok_d = 1'b0;
          end
        end else if (col_q == ColSep) begin
          if (ok_q && byte_i != ChrDash) begin
            found_d = 1'b1;
          end
        end
      end

      if (found_d && cr_q && byte_i == ChrLf) begin
        res_o.emit   = 1'b1;
        res_o.code   = acc_d;
        res_o.status = (acc_d == expected_code_i) ? StMatch : StDiffer;
      end else begin
        cnt_d = cnt_q + 1'b1;
        cr_d  = (byte_i == ChrCr);
        if (byte_i == ChrLf) begin
          col_d = '0;
          ok_d  = 1'b1;
          if (!found_d) begin
            acc_d = '0;
          end
        end else if (col_q < ColSat) begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  // Parse state; any result clears it for the next reply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      col_q   <= '0;
      ok_q    <= 1'b1;
      acc_q   <= '0;
      found_q <= 1'b0;
      cr_q    <= 1'b0;
    end else if (step_i) begin
      if (res_o.emit) begin
        cnt_q   <= '0;
        col_q   <= '0;
        ok_q    <= 1'b1;
        acc_q   <= '0;
        found_q <= 1'b0;
        cr_q    <= 1'b0;
      end else begin
        cnt_q   <= cnt_d;
        col_q   <= col_d;
        ok_q    <= ok_d;
        acc_q   <= acc_d;
        found_q <= found_d;
        cr_q    <= cr_d;
      end
    end
  end

endmodule : srcp_parse

`default_nettype wire

/* rtl/smtp_reply_code_parser_core.sv */
// ----------------------------------------------------------------------------
// SMTP reply code parser core
// Parses a byte stream of SMTP server replies and reports the reply code.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one reply byte per transaction in tdata, with
//   tuser high for a "link closed" event instead of a byte. The master stream
//   gives one result per finished reply: the three-digit code in tdata and
//   the status in tuser (match, differ, reply too long, link closed).
//   The APB port holds the expected code at address 0 (reset value 220).
// Throughput and pipeline:
//   One byte per cycle is sustained while the result register can drain. A
//   byte is captured in the input register, parsed combinationally from it
//   and its result, if any, is captured in the result register, which
//   presents it on the master stream. The parse step is one compare and
//   accumulate.
// Stalls and reset:
//   While a result waits on a low m_axis_tready_i, the byte in the input
//   register waits too and s_axis_tready_o drops once that register is full.
//   Reset empties both registers, clears the parse state and sets the
//   expected code to 220.
// ----------------------------------------------------------------------------
`default_nettype none

module smtp_reply_code_parser_core
  import srcp_pkg::*;
#(
  parameter int unsigned MAX_REPLY_BYTES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream: tdata = reply_byte[7:0]; tuser = kind[0].
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tuser_i,
  // Master stream: tdata = reply_code[9:0], zeros [15:10]; tuser = status[1:0].
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,
  // APB configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] AddrExpectedCode = 2'd0;

  logic [CodeW-1:0] expected_code_q;
  logic             in_valid_q;
  logic             in_kind_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [CodeW-1:0] out_code_q;
  logic             advance;
  logic             step;
  srcp_result_t     res;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == AddrExpectedCode) ? 32'(expected_code_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_code_q <= ExpectedCodeReset;
    end else if (psel && penable && pwrite && pready && paddr == AddrExpectedCode) begin
      expected_code_q <= pwdata[CodeW-1:0];
    end
  end

  // The parse stage moves whenever the result register can take a result.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  srcp_parse #(
    .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .kind_i         (in_kind_q),
    .byte_i         (in_byte_q),
    .expected_code_i(expected_code_q),
    .res_o          (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_status_q <= res.status;
      out_code_q   <= res.code;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - CodeW){1'b0}}, out_code_q};
  assign m_axis_tuser_o  = out_status_q;

  // Error results never carry a code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == '0)
    else $error("error result with nonzero code");

  // A parsed code is always three decimal digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_code_q <= CodeW'(999))
    else $error("reply code out of range");

  // A byte held during an output stall is not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |=> in_valid_q)
    else $error("input byte lost during stall");

endmodule : smtp_reply_code_parser_core

`default_nettype wire
